@@ rtl/reso_pkg.sv @@
`default_nettype none

package reso_pkg;

    // Ring geometry
    localparam int RING_DEPTH = 16;
    localparam int SLOT_W     = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);

    // Field widths
    localparam int HANDLE_W   = 32;
    localparam int SIZE_W     = 16;
    localparam int POS_W      = 20;
    localparam int OFFSET_W   = 16;
    localparam int OSLOT_W    = 4;
    localparam int REC_W      = HANDLE_W + SIZE_W;

    // Running byte total: RING_DEPTH records of up to 2^16-1 bytes, and wide
    // enough to hold any byte position without loss.
    localparam int SUM_W      = POS_W + 1 + SLOT_W;

    // Stream data widths, padded to whole bytes
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 72;

    // Request kinds (carried in tuser)
    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_FIND = 1'b1;

    typedef logic [SLOT_W-1:0] t_slot;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic                found;
        logic [HANDLE_W-1:0] handle;
        logic [SIZE_W-1:0]   size;
        logic [OFFSET_W-1:0] offset;
        logic [OSLOT_W-1:0]  slot;
    } t_result;

    function automatic t_slot next_slot(input t_slot s);
        t_slot r;
        if (s == t_slot'(RING_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = s + t_slot'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/ring_entry_store_offset_lookup.sv @@
// Add request, or find on an empty ring: goes straight to the result state, which loads
// the output register and returns to idle for the next acceptance.
// Find request: walks the stored records oldest first, N of them (1 to RING_DEPTH), up to
// a hit, one record a cycle through the single record memory read port.
// A stalled result port holds one finished result in front of the output register.
// Synchronous active-low reset clears the slots, full flag and all valids.
`default_nettype none

module ring_entry_store_offset_lookup (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Request stream
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // [31:0] entry_handle, [47:32] entry_size, [67:48] byte_pos, [71:68] zero
    input  wire logic [reso_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // [0] req_type
    input  wire logic                               i_s_tuser,
    // Result stream
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    // [31:0] found_handle, [47:32] found_size, [63:48] offset_in_entry,
    // [67:64] found_slot, [71:68] zero
    output logic      [reso_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    // [0] found
    output logic                                    o_m_tuser
);

    // ------------------------------------------------------------------
    // Request unpacking
    // ------------------------------------------------------------------
    logic                              w_in_acc;
    logic [reso_pkg::HANDLE_W-1:0]     w_in_handle;
    logic [reso_pkg::SIZE_W-1:0]       w_in_size;
    logic [reso_pkg::POS_W-1:0]        w_in_pos;

    assign w_in_acc    = i_s_tvalid && o_s_tready;
    assign w_in_handle = i_s_tdata[31:0];
    assign w_in_size   = i_s_tdata[47:32];
    assign w_in_pos    = i_s_tdata[67:48];

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    reso_pkg::t_state                  r_state, n_state;
    reso_pkg::t_slot                   r_wr_slot, n_wr_slot;
    reso_pkg::t_slot                   r_rd_slot, n_rd_slot;
    logic                              r_full, n_full;

    // Walk: issue side runs one record ahead of the check side
    reso_pkg::t_slot                   r_iaddr, n_iaddr;
    logic [reso_pkg::CNT_W-1:0]        r_ileft, n_ileft;
    reso_pkg::t_slot                   r_caddr, n_caddr;
    logic [reso_pkg::CNT_W-1:0]        r_cleft, n_cleft;
    logic                              r_dvalid, n_dvalid;
    logic [reso_pkg::SUM_W-1:0]        r_run, n_run;
    logic [reso_pkg::POS_W-1:0]        r_pos, n_pos;

    reso_pkg::t_result                 r_res, n_res;
    reso_pkg::t_result                 r_out, n_out;
    logic                              r_out_valid, n_out_valid;

    // Record memory
    logic                              w_ram_wr_en;
    logic                              w_ram_rd_en;
    logic [reso_pkg::REC_W-1:0]        w_ram_rd_data;

    reso_ram #(
        .W     (reso_pkg::REC_W),
        .DEPTH (reso_pkg::RING_DEPTH)
    ) u_rec_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_wr_en),
        .i_wr_addr (r_wr_slot),
        .i_wr_data ({w_in_handle, w_in_size}),
        .i_rd_en   (w_ram_rd_en),
        .i_rd_addr (r_iaddr),
        .o_rd_data (w_ram_rd_data)
    );

    // ------------------------------------------------------------------
    // Compare unit: one record checked per cycle
    // ------------------------------------------------------------------
    logic [reso_pkg::SIZE_W-1:0]       w_rec_size;
    logic [reso_pkg::HANDLE_W-1:0]     w_rec_handle;
    logic [reso_pkg::SUM_W-1:0]        w_run_end;
    logic [reso_pkg::SUM_W-1:0]        w_pos_ext;
    logic [reso_pkg::SUM_W-1:0]        w_offset_wide;
    logic                              w_hit;
    logic                              w_last_check;
    logic [reso_pkg::SLOT_W+3:0]       w_slot_ext;

    assign w_rec_size    = w_ram_rd_data[reso_pkg::SIZE_W-1:0];
    assign w_rec_handle  = w_ram_rd_data[reso_pkg::REC_W-1:reso_pkg::SIZE_W];
    assign w_pos_ext     = reso_pkg::SUM_W'(r_pos);
    assign w_run_end     = r_run + reso_pkg::SUM_W'(w_rec_size);
    assign w_hit         = r_dvalid && (w_pos_ext < w_run_end);
    assign w_offset_wide = w_pos_ext - r_run;
    assign w_last_check  = r_dvalid && (r_cleft == reso_pkg::CNT_W'(1));
    // found_slot keeps the low four bits of the slot index
    assign w_slot_ext    = {4'b0000, r_caddr};

    // Number of stored records, oldest first
    logic [reso_pkg::CNT_W-1:0]        w_count;
    always_comb begin
        if (r_full) begin
            w_count = reso_pkg::CNT_W'(reso_pkg::RING_DEPTH);
        end else if (r_wr_slot >= r_rd_slot) begin
            w_count = reso_pkg::CNT_W'(r_wr_slot) - reso_pkg::CNT_W'(r_rd_slot);
        end else begin
            // write slot has wrapped past the end of the ring
            w_count = reso_pkg::CNT_W'(r_wr_slot)
                    + reso_pkg::CNT_W'(reso_pkg::RING_DEPTH)
                    - reso_pkg::CNT_W'(r_rd_slot);
        end
    end

    logic w_out_free;
    assign w_out_free = !r_out_valid || i_m_tready;

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            reso_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_s_tuser == reso_pkg::REQ_FIND && w_count != '0) begin
                        n_state = reso_pkg::ST_WALK;
                    end else begin
                        n_state = reso_pkg::ST_RESULT;
                    end
                end
            end
            reso_pkg::ST_WALK: begin
                if (w_hit || w_last_check) begin
                    n_state = reso_pkg::ST_RESULT;
                end
            end
            reso_pkg::ST_RESULT: begin
                if (w_out_free) begin
                    n_state = reso_pkg::ST_IDLE;
                end
            end
            default: n_state = reso_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb begin
        o_s_tready  = 1'b0;
        w_ram_wr_en = 1'b0;
        w_ram_rd_en = 1'b0;
        unique case (r_state)
            reso_pkg::ST_IDLE: begin
                o_s_tready  = 1'b1;
                w_ram_wr_en = i_s_tvalid && (i_s_tuser == reso_pkg::REQ_ADD);
            end
            reso_pkg::ST_WALK: begin
                w_ram_rd_en = (r_ileft != '0);
            end
            reso_pkg::ST_RESULT: begin
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    always_comb begin
        n_wr_slot   = r_wr_slot;
        n_rd_slot   = r_rd_slot;
        n_full      = r_full;
        n_iaddr     = r_iaddr;
        n_ileft     = r_ileft;
        n_caddr     = r_caddr;
        n_cleft     = r_cleft;
        n_dvalid    = 1'b0;
        n_run       = r_run;
        n_pos       = r_pos;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        // drop the result once taken
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            reso_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_res = '0;
                    if (i_s_tuser == reso_pkg::REQ_ADD) begin
                        // overwrite the oldest record when full
                        if (r_full) begin
                            n_rd_slot = reso_pkg::next_slot(r_rd_slot);
                        end
                        n_wr_slot = reso_pkg::next_slot(r_wr_slot);
                        n_full    = (n_wr_slot == n_rd_slot);
                    end else begin
                        n_pos   = w_in_pos;
                        n_run   = '0;
                        n_iaddr = r_rd_slot;
                        n_ileft = w_count;
                        n_cleft = w_count;
                    end
                end
            end
            reso_pkg::ST_WALK: begin
                // issue the next record read
                if (w_ram_rd_en) begin
                    n_iaddr  = reso_pkg::next_slot(r_iaddr);
                    n_ileft  = r_ileft - reso_pkg::CNT_W'(1);
                    n_caddr  = r_iaddr;
                    n_dvalid = 1'b1;
                end
                // check the record read last cycle
                if (w_hit) begin
                    n_res.found  = 1'b1;
                    n_res.handle = w_rec_handle;
                    n_res.size   = w_rec_size;
                    n_res.offset = w_offset_wide[reso_pkg::OFFSET_W-1:0];
                    n_res.slot   = w_slot_ext[reso_pkg::OSLOT_W-1:0];
                    n_ileft      = '0;
                    n_dvalid     = 1'b0;
                end else if (r_dvalid) begin
                    n_run   = w_run_end;
                    n_cleft = r_cleft - reso_pkg::CNT_W'(1);
                end
            end
            reso_pkg::ST_RESULT: begin
                if (w_out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= reso_pkg::ST_IDLE;
            r_wr_slot   <= '0;
            r_rd_slot   <= '0;
            r_full      <= 1'b0;
            r_ileft     <= '0;
            r_dvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_slot   <= n_wr_slot;
            r_rd_slot   <= n_rd_slot;
            r_full      <= n_full;
            r_ileft     <= n_ileft;
            r_dvalid    <= n_dvalid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_iaddr <= n_iaddr;
        r_caddr <= n_caddr;
        r_cleft <= n_cleft;
        r_run   <= n_run;
        r_pos   <= n_pos;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    // ------------------------------------------------------------------
    // Result stream
    // ------------------------------------------------------------------
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.found;
    assign o_m_tdata  = {4'b0000, r_out.slot, r_out.offset, r_out.size, r_out.handle};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_full_slots_meet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> (r_wr_slot == r_rd_slot))
        else $error("ring full while write and read slots differ");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_s_tready)
        else $error("request taken while previous one still in work");

    a_issue_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == reso_pkg::ST_WALK) |-> (r_ileft <= r_cleft))
        else $error("walk issued more reads than records left to check");

    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == reso_pkg::ST_RESULT) && w_out_free) |=> o_m_tvalid)
        else $error("result not presented after completion");

endmodule

`default_nettype wire

@@ rtl/reso_ram.sv @@
`default_nettype none

module reso_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [W-1:0]             i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [W-1:0]             o_rd_data
);

    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire
